// File: hw/rtl/sld_pkg.sv
package sld_pkg;

    localparam int DATA_W   = 8;
    localparam int WIDTH_W  = 10;
    localparam int HEIGHT_W = 9;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;
    localparam int LIT_W    = 7;
    localparam int ADDR_W   = 19;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd3;

    localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = 10'd640;
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 9'd480;
    localparam logic [COL_W-1:0]    RST_ORIGIN_X     = 10'd197;
    localparam logic [ROW_W-1:0]    RST_ORIGIN_Y     = 9'd118;

    localparam logic [ROW_W-1:0] ROW_MAX = 9'h1FF;

    typedef struct packed {
        logic [WIDTH_W-1:0]  frame_width;
        logic [HEIGHT_W-1:0] frame_height;
        logic [COL_W-1:0]    origin_x;
        logic [ROW_W-1:0]    origin_y;
    } t_cfg;

endpackage

// File: hw/rtl/sld_ifs.sv
interface sld_in_if;
    logic                        valid;
    logic                        ready;
    logic [sld_pkg::DATA_W-1:0]  data_byte;
    logic                        frame_start;
    logic                        key_frame;

    modport source (output valid, data_byte, frame_start, key_frame, input ready);
    modport sink   (input valid, data_byte, frame_start, key_frame, output ready);
endinterface

interface sld_out_if;
    logic                        valid;
    logic                        ready;
    logic [sld_pkg::ADDR_W-1:0]  pixel_addr;
    logic [sld_pkg::DATA_W-1:0]  pixel_value;
    logic                        off_screen;

    modport source (output valid, pixel_addr, pixel_value, off_screen, input ready);
    modport sink   (input valid, pixel_addr, pixel_value, off_screen, output ready);
endinterface

interface sld_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sld_pkg::CFG_IDX_W-1:0]  index;
    logic [15:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/sld_cfg_regs.sv
module sld_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sld_cfg_if.sink         i_cfg,
    output sld_pkg::t_cfg   o_cfg
);

    sld_pkg::t_cfg r_cfg;
    sld_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                sld_pkg::CFG_FRAME_WIDTH:  n_cfg.frame_width  = i_cfg.data[sld_pkg::WIDTH_W-1:0];
                sld_pkg::CFG_FRAME_HEIGHT: n_cfg.frame_height = i_cfg.data[sld_pkg::HEIGHT_W-1:0];
                sld_pkg::CFG_ORIGIN_X:     n_cfg.origin_x     = i_cfg.data[sld_pkg::COL_W-1:0];
                sld_pkg::CFG_ORIGIN_Y:     n_cfg.origin_y     = i_cfg.data[sld_pkg::ROW_W-1:0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= sld_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height <= sld_pkg::RST_FRAME_HEIGHT;
            r_cfg.origin_x     <= sld_pkg::RST_ORIGIN_X;
            r_cfg.origin_y     <= sld_pkg::RST_ORIGIN_Y;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: hw/rtl/sld_addr_unit.sv
module sld_addr_unit #(
    parameter int SCREEN_STRIDE = 640,
    parameter int SCREEN_ROWS   = 480
) (
    input  logic                        i_clk,
    input  logic                        i_mul_en,
    input  logic [sld_pkg::ROW_W-1:0]   i_origin_y,
    input  logic [sld_pkg::COL_W-1:0]   i_origin_x,
    input  logic [sld_pkg::ROW_W-1:0]   i_row,
    input  logic [sld_pkg::COL_W-1:0]   i_col,
    output logic [sld_pkg::ADDR_W-1:0]  o_addr,
    output logic                        o_off
);

    localparam int ROWSUM_W = sld_pkg::ROW_W + 1;
    localparam int COLSUM_W = sld_pkg::COL_W + 1;
    localparam int ROWSUM_MAX = (1 << ROWSUM_W) - 1;
    localparam int COLSUM_MAX = (1 << COLSUM_W) - 1;
    localparam int PROD_W = $clog2(ROWSUM_MAX * SCREEN_STRIDE + 1);
    localparam int SUM_W  = $clog2(ROWSUM_MAX * SCREEN_STRIDE + COLSUM_MAX + 1);
    localparam int LIMIT  = SCREEN_STRIDE * SCREEN_ROWS;
    localparam int LIM_W  = $clog2(LIMIT + 1);
    localparam int CMP_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;

    logic [ROWSUM_W-1:0] row_sum;
    logic [PROD_W-1:0]   r_prod;
    logic [CMP_W-1:0]    full_addr;
    logic [CMP_W-1:0]    sel_addr;

    assign row_sum = ROWSUM_W'(i_origin_y) + ROWSUM_W'(i_row);

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= PROD_W'(row_sum) * PROD_W'(SCREEN_STRIDE);
        end
    end

    assign full_addr = CMP_W'(r_prod) + CMP_W'(i_origin_x) + CMP_W'(i_col);
    assign o_off     = (full_addr >= CMP_W'(LIMIT));
    assign sel_addr  = o_off ? CMP_W'(LIMIT - 1) : full_addr;
    assign o_addr    = sld_pkg::ADDR_W'(sel_addr);

endmodule

// File: hw/rtl/skip_literal_delta_frame_decoder_top.sv
// Decodes the body bytes of skip/literal delta animation frames into screen pixel writes.
// One input word is taken in the idle state only. A control byte that only sets a literal
// count is handled in the idle state alone; a pixel word passes through accept, row
// multiply, address add and clamp, and position update, repeating the update once per row
// wrapped, and may wait in the add state for the output register to drain; a skip goes
// from accept straight to position update, repeating it once per row wrapped, since the
// single subtract/compare unit peels off one frame_width per cycle. The result register
// lets the next byte be taken while a pixel waits downstream. frame_width 0 behaves as 1;
// key frame bytes past frame_height rows and all control bytes produce no pixel.
module skip_literal_delta_frame_decoder_top #(
    parameter int SCREEN_STRIDE = 640,
    parameter int SCREEN_ROWS   = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sld_in_if.sink      i_in,
    sld_out_if.source   o_out,
    sld_cfg_if.sink     i_cfg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_ADV  = 2'd3;

    localparam int X_W = sld_pkg::COL_W + 1;

    sld_pkg::t_cfg cfg;

    logic [1:0]                   r_state, n_state;
    logic [sld_pkg::COL_W-1:0]    r_col, n_col;
    logic [sld_pkg::ROW_W-1:0]    r_row, n_row;
    logic [sld_pkg::LIT_W-1:0]    r_lit, n_lit;
    logic                         r_key, n_key;
    logic [X_W-1:0]               r_x, n_x;
    logic [sld_pkg::ROW_W-1:0]    r_y, n_y;
    logic [sld_pkg::DATA_W-1:0]   r_val, n_val;
    logic                         r_ovalid, n_ovalid;
    logic [sld_pkg::ADDR_W-1:0]   r_oaddr, n_oaddr;
    logic [sld_pkg::DATA_W-1:0]   r_oval, n_oval;
    logic                         r_ooff, n_ooff;

    logic                         accept;
    logic [sld_pkg::COL_W-1:0]    col_e;
    logic [sld_pkg::ROW_W-1:0]    row_e;
    logic [sld_pkg::LIT_W-1:0]    lit_e;
    logic                         key_e;
    logic [sld_pkg::WIDTH_W-1:0]  w_eff;
    logic                         wrap;
    logic [sld_pkg::ADDR_W-1:0]   calc_addr;
    logic                         calc_off;

    function automatic logic HEIGHT_FIT(input logic [sld_pkg::ROW_W-1:0] row,
                                        input logic [sld_pkg::HEIGHT_W-1:0] height);
        HEIGHT_FIT = (row < height);
    endfunction

    sld_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    sld_addr_unit #(
        .SCREEN_STRIDE (SCREEN_STRIDE),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) u_addr (
        .i_clk      (i_clk),
        .i_mul_en   (r_state == S_MUL),
        .i_origin_y (cfg.origin_y),
        .i_origin_x (cfg.origin_x),
        .i_row      (r_row),
        .i_col      (r_col),
        .o_addr     (calc_addr),
        .o_off      (calc_off)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign accept            = i_in.valid && i_in.ready;
    assign o_out.valid       = r_ovalid;
    assign o_out.pixel_addr  = r_oaddr;
    assign o_out.pixel_value = r_oval;
    assign o_out.off_screen  = r_ooff;

    assign col_e = i_in.frame_start ? '0 : r_col;
    assign row_e = i_in.frame_start ? '0 : r_row;
    assign lit_e = i_in.frame_start ? '0 : r_lit;
    assign key_e = i_in.frame_start ? i_in.key_frame : r_key;

    assign w_eff = (cfg.frame_width == '0) ? sld_pkg::WIDTH_W'(1) : cfg.frame_width;
    assign wrap  = (r_x >= X_W'(w_eff));

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_lit    = r_lit;
        n_key    = r_key;
        n_x      = r_x;
        n_y      = r_y;
        n_val    = r_val;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oaddr  = r_oaddr;
        n_oval   = r_oval;
        n_ooff   = r_ooff;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_col = col_e;
                    n_row = row_e;
                    n_lit = lit_e;
                    n_key = key_e;
                    n_y   = row_e;
                    n_val = i_in.data_byte;
                    n_x   = X_W'(col_e) + X_W'(1);
                    if (key_e) begin
                        if (HEIGHT_FIT(row_e, cfg.frame_height)) begin
                            n_state = S_MUL;
                        end
                    end else if (lit_e != '0) begin
                        n_lit   = lit_e - sld_pkg::LIT_W'(1);
                        n_state = S_MUL;
                    end else if (i_in.data_byte[7]) begin
                        n_x     = X_W'(col_e) + X_W'(i_in.data_byte[6:0]);
                        n_state = S_ADV;
                    end else begin
                        n_lit = i_in.data_byte[sld_pkg::LIT_W-1:0];
                    end
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oaddr  = calc_addr;
                    n_oval   = r_val;
                    n_ooff   = calc_off;
                    n_state  = S_ADV;
                end
            end
            S_ADV: begin
                if (wrap) begin
                    n_x = r_x - X_W'(w_eff);
                    if (r_y != sld_pkg::ROW_MAX) begin
                        n_y = r_y + sld_pkg::ROW_W'(1);
                    end
                end else begin
                    n_col   = r_x[sld_pkg::COL_W-1:0];
                    n_row   = r_y;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_lit    <= '0;
            r_key    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_lit    <= n_lit;
            r_key    <= n_key;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_val   <= n_val;
        r_oaddr <= n_oaddr;
        r_oval  <= n_oval;
        r_ooff  <= n_ooff;
    end

endmodule

// File: verif/sld_pixel_checker.sv
module sld_pixel_checker #(
    parameter int SCREEN_STRIDE = 640,
    parameter int SCREEN_ROWS   = 480
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sld_in_if    i_in,
    sld_out_if   i_out,
    sld_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sld_pkg::ADDR_W-1:0] addr;
        logic [sld_pkg::DATA_W-1:0] value;
        logic                       off;
    } t_pixel;

    logic [sld_pkg::WIDTH_W-1:0]  frame_width;
    logic [sld_pkg::HEIGHT_W-1:0] frame_height;
    logic [sld_pkg::COL_W-1:0]    origin_x;
    logic [sld_pkg::ROW_W-1:0]    origin_y;

    logic [sld_pkg::COL_W-1:0]    col_pos;
    logic [sld_pkg::ROW_W-1:0]    row_pos;
    logic [sld_pkg::LIT_W-1:0]    literal_left;
    logic                         frame_is_key;

    t_pixel expected_pixels[$];
    int     fails = 0;
    int     pixels_seen = 0;

    task automatic report(input string msg);
        if (fails < 100) begin
            $display("mismatch: %s", msg);
        end
        fails++;
    endtask

    task automatic step_position(input int unsigned count);
        int unsigned w;
        int unsigned x;
        int unsigned y;
        w = (frame_width == '0) ? 1 : int'(frame_width);
        x = col_pos + count;
        y = row_pos;
        while (x >= w) begin
            x -= w;
            if (y < sld_pkg::ROW_MAX) begin
                y++;
            end
        end
        col_pos = x[sld_pkg::COL_W-1:0];
        row_pos = y[sld_pkg::ROW_W-1:0];
    endtask

    function automatic t_pixel place_pixel(input logic [sld_pkg::DATA_W-1:0] value);
        t_pixel          p;
        longint unsigned limit;
        longint unsigned addr;
        limit = longint'(SCREEN_STRIDE) * longint'(SCREEN_ROWS);
        addr  = (64'(origin_y) + 64'(row_pos)) * longint'(SCREEN_STRIDE)
                + 64'(origin_x) + 64'(col_pos);
        p.off = 1'b0;
        if (addr >= limit) begin
            addr  = limit - 1;
            p.off = 1'b1;
        end
        p.addr  = addr[sld_pkg::ADDR_W-1:0];
        p.value = value;
        return p;
    endfunction

    task automatic predict_word(input logic [sld_pkg::DATA_W-1:0] b, input logic fs,
                                input logic kf);
        if (fs) begin
            col_pos      = '0;
            row_pos      = '0;
            literal_left = '0;
            frame_is_key = kf;
        end
        if (frame_is_key) begin
            if (row_pos < frame_height) begin
                expected_pixels.push_back(place_pixel(b));
                step_position(1);
            end
        end else if (literal_left != '0) begin
            expected_pixels.push_back(place_pixel(b));
            step_position(1);
            literal_left = literal_left - 1'b1;
        end else if (b[7]) begin
            step_position(b[6:0]);
        end else begin
            literal_left = b[sld_pkg::LIT_W-1:0];
        end
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            report($sformatf("pixel %0d: none expected, got addr %h value %h",
                             pixels_seen, i_out.pixel_addr, i_out.pixel_value));
        end else begin
            want = expected_pixels.pop_front();
            if (i_out.pixel_addr !== want.addr) begin
                report($sformatf("pixel %0d: addr %h, want %h",
                                 pixels_seen, i_out.pixel_addr, want.addr));
            end
            if (i_out.pixel_value !== want.value) begin
                report($sformatf("pixel %0d: value %h, want %h",
                                 pixels_seen, i_out.pixel_value, want.value));
            end
            if (i_out.off_screen !== want.off) begin
                report($sformatf("pixel %0d: off_screen %b, want %b",
                                 pixels_seen, i_out.off_screen, want.off));
            end
        end
        pixels_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_width  = sld_pkg::RST_FRAME_WIDTH;
            frame_height = sld_pkg::RST_FRAME_HEIGHT;
            origin_x     = sld_pkg::RST_ORIGIN_X;
            origin_y     = sld_pkg::RST_ORIGIN_Y;
            col_pos      = '0;
            row_pos      = '0;
            literal_left = '0;
            frame_is_key = 1'b0;
            expected_pixels.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                check_pixel();
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    sld_pkg::CFG_FRAME_WIDTH:
                        frame_width  = i_cfg.data[sld_pkg::WIDTH_W-1:0];
                    sld_pkg::CFG_FRAME_HEIGHT:
                        frame_height = i_cfg.data[sld_pkg::HEIGHT_W-1:0];
                    sld_pkg::CFG_ORIGIN_X:
                        origin_x     = i_cfg.data[sld_pkg::COL_W-1:0];
                    sld_pkg::CFG_ORIGIN_Y:
                        origin_y     = i_cfg.data[sld_pkg::ROW_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                predict_word(i_in.data_byte, i_in.frame_start, i_in.key_frame);
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fails;
    end

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_STRIDE  = 640;
    localparam int SCREEN_ROWS    = 480;
    localparam int RANDOM_WORDS   = 1350;
    localparam int DRAIN_CYCLES   = 1300;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    int fail_count;
    int pending;
    int words_sent  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    sld_in_if  in_ch();
    sld_out_if out_ch();
    sld_cfg_if cfg_ch();

    skip_literal_delta_frame_decoder_top #(
        .SCREEN_STRIDE(SCREEN_STRIDE),
        .SCREEN_ROWS  (SCREEN_ROWS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    sld_pixel_checker #(
        .SCREEN_STRIDE(SCREEN_STRIDE),
        .SCREEN_ROWS  (SCREEN_ROWS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                stall_left <= idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic fs, input logic kf);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.frame_start <= fs;
        in_ch.key_frame   <= kf;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_reg(input logic [sld_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all pixels, then let a long skip finish before touching registers
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_reg_value(input logic [sld_pkg::CFG_IDX_W-1:0] idx);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        case (idx)
            sld_pkg::CFG_FRAME_WIDTH: begin
                case (r)
                    1: return 16'd0;
                    2: return 16'd1;
                    3: return 16'd640;
                    4: return 16'd1023;
                    5, 6: return 16'($urandom_range(2, 8));
                    default: return 16'($urandom_range(1, 640));
                endcase
            end
            sld_pkg::CFG_FRAME_HEIGHT: begin
                case (r)
                    1: return 16'd0;
                    2: return 16'd1;
                    3: return 16'd480;
                    4: return 16'd511;
                    5, 6: return 16'($urandom_range(2, 6));
                    default: return 16'($urandom_range(1, 480));
                endcase
            end
            sld_pkg::CFG_ORIGIN_X: begin
                case (r)
                    1: return 16'd0;
                    2: return 16'd639;
                    3: return 16'd1023;
                    default: return 16'($urandom_range(0, 639));
                endcase
            end
            default: begin
                case (r)
                    1: return 16'd0;
                    2: return 16'd479;
                    3: return 16'd511;
                    default: return 16'($urandom_range(0, 479));
                endcase
            end
        endcase
    endfunction

    task automatic delta_op(input logic fs);
        int unsigned r;
        int unsigned n;
        int unsigned run;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            send_word(8'h80 | 8'($urandom_range(0, 127)), fs, 1'b0);
        end else begin
            if (r < 40) begin
                n = 0;
            end else if (r < 46) begin
                n = $urandom_range(7, 127);
            end else begin
                n = $urandom_range(1, 6);
            end
            send_word(8'(n), fs, 1'b0);
            run = n;
            if ($urandom_range(0, 9) == 0) begin
                run = $urandom_range(0, n);
            end
            repeat (run) send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic key_frame_words();
        int unsigned n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
        send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic delta_frame_words();
        delta_op(1'b1);
        repeat ($urandom_range(1, 8)) delta_op(1'b0);
    endtask

    initial begin
        int          phase_end;
        int unsigned r;

        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.data_byte   <= '0;
        in_ch.frame_start <= 1'b0;
        in_ch.key_frame   <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= sld_pkg::CFG_FRAME_WIDTH;
        cfg_ch.data       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // key frame at reset settings
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
        // delta: literals, skips of 127 and 0, zero literal, restart inside a run
        send_word(8'h02, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h7F, 1'b0, 1'b0);
        send_word(8'h11, 1'b0, 1'b0);
        send_word(8'h03, 1'b1, 1'b0);
        send_word(8'hAA, 1'b0, 1'b0);

        // zero width, one row, origin past the screen edge
        settle();
        write_reg(sld_pkg::CFG_FRAME_WIDTH, 16'hFC00);
        write_reg(sld_pkg::CFG_FRAME_HEIGHT, 16'd1);
        write_reg(sld_pkg::CFG_ORIGIN_X, 16'h03FF);
        write_reg(sld_pkg::CFG_ORIGIN_Y, 16'd479);
        send_word(8'h01, 1'b1, 1'b1);
        send_word(8'h02, 1'b0, 1'b0);
        send_word(8'h03, 1'b0, 1'b0);
        // saturate the row counter
        send_word(8'hFF, 1'b1, 1'b0);
        repeat (4) send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h01, 1'b0, 1'b0);
        send_word(8'h44, 1'b0, 1'b0);

        // narrow the width while mid frame
        settle();
        write_reg(sld_pkg::CFG_FRAME_WIDTH, 16'd640);
        write_reg(sld_pkg::CFG_ORIGIN_X, 16'd0);
        write_reg(sld_pkg::CFG_ORIGIN_Y, 16'd0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        settle();
        write_reg(sld_pkg::CFG_FRAME_WIDTH, 16'd5);
        send_word(8'h01, 1'b0, 1'b0);
        send_word(8'h33, 1'b0, 1'b0);
        send_word(8'h81, 1'b0, 1'b0);

        words_sent = 0;
        phase_end  = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (words_sent >= phase_end) begin
                settle();
                write_reg(sld_pkg::CFG_FRAME_WIDTH, pick_reg_value(sld_pkg::CFG_FRAME_WIDTH));
                write_reg(sld_pkg::CFG_FRAME_HEIGHT, pick_reg_value(sld_pkg::CFG_FRAME_HEIGHT));
                write_reg(sld_pkg::CFG_ORIGIN_X, pick_reg_value(sld_pkg::CFG_ORIGIN_X));
                write_reg(sld_pkg::CFG_ORIGIN_Y, pick_reg_value(sld_pkg::CFG_ORIGIN_Y));
                calm      = ($urandom_range(0, 3) == 0);
                phase_end = words_sent + $urandom_range(80, 150);
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                key_frame_words();
            end else if (r < 85) begin
                delta_frame_words();
            end else if (r < 92) begin
                repeat ($urandom_range(1, 3)) delta_op(1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0),
                              1'($urandom_range(0, 1)));
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sld_pkg.sv
hw/rtl/sld_ifs.sv
hw/rtl/sld_cfg_regs.sv
hw/rtl/sld_addr_unit.sv
hw/rtl/skip_literal_delta_frame_decoder_top.sv
verif/sld_pixel_checker.sv
verif/tb.sv
